FILE: src/assert_macros.svh
// Assertion macros shared by the byte CPU RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define BCPU_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// condition must never be true outside reset
`define BCPU_NEVER(label, clk, rst_n, cond, msg) \
    `BCPU_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

FILE: src/bcpu_pkg.sv
// Shared types and constants for the byte CPU instruction step block.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcpu_pkg;

    // opcode bytes
    localparam logic [7:0] OP_NOP   = 8'h00;
    localparam logic [7:0] OP_LOAD  = 8'h01;
    localparam logic [7:0] OP_ADD   = 8'h02;
    localparam logic [7:0] OP_SUB   = 8'h03;
    localparam logic [7:0] OP_STORE = 8'h04;
    localparam logic [7:0] OP_READ  = 8'h09;
    localparam logic [7:0] OP_WRITE = 8'h0A;
    localparam logic [7:0] OP_JMP   = 8'h0B;
    localparam logic [7:0] OP_CALL  = 8'h0C;
    localparam logic [7:0] OP_RET   = 8'h0D;
    localparam logic [7:0] OP_BEQ   = 8'h0E;
    localparam logic [7:0] OP_BNE   = 8'h0F;
    localparam logic [7:0] OP_INT   = 8'h10;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_OP    = 2'd1;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    // instruction queue between decode and execute
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        K_NOP,
        K_LOAD,
        K_ADD,
        K_SUB,
        K_STORE,
        K_READ,
        K_WRITE,
        K_JMP,
        K_CALL,
        K_RET,
        K_BEQ,
        K_BNE,
        K_INT,
        K_BAD
    } t_op_kind;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] first_operand;
        logic [7:0] second_operand;
        logic [7:0] read_value;
    } t_in_word;

    typedef struct packed {
        logic [7:0] next_pc;
        logic       halted;
        logic       reg_write_en;
        logic [1:0] reg_write_index;
        logic [7:0] reg_write_value;
        logic       store_en;
        logic [7:0] store_addr;
        logic [7:0] store_data;
        logic       out_en;
        logic [7:0] out_value;
        logic       interrupt;
        logic [1:0] error_code;
    } t_out_word;

    // decoded instruction as held in the queue
    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] opa;
        logic [7:0] opb;
        logic [7:0] rd_val;
        logic [1:0] step;    // instruction length in bytes
    } t_uop;

endpackage

`default_nettype wire

FILE: src/bcpu_decode.sv
// Front end: classifies the opcode byte and computes the instruction length.
// Depends on bcpu_pkg.
`default_nettype none

module bcpu_decode
    import bcpu_pkg::*;
(
    input  t_in_word i_word,
    output t_uop     o_uop
);

    t_op_kind   kind;
    logic [1:0] step;

    always_comb begin
        unique case (i_word.opcode)
            OP_NOP:   begin kind = K_NOP;   step = 2'd1; end
            OP_LOAD:  begin kind = K_LOAD;  step = 2'd3; end
            OP_ADD:   begin kind = K_ADD;   step = 2'd3; end
            OP_SUB:   begin kind = K_SUB;   step = 2'd3; end
            OP_STORE: begin kind = K_STORE; step = 2'd3; end
            OP_READ:  begin kind = K_READ;  step = 2'd2; end
            OP_WRITE: begin kind = K_WRITE; step = 2'd2; end
            OP_JMP:   begin kind = K_JMP;   step = 2'd2; end
            OP_CALL:  begin kind = K_CALL;  step = 2'd2; end
            OP_RET:   begin kind = K_RET;   step = 2'd1; end
            OP_BEQ:   begin kind = K_BEQ;   step = 2'd3; end
            OP_BNE:   begin kind = K_BNE;   step = 2'd3; end
            OP_INT:   begin kind = K_INT;   step = 2'd1; end
            default:  begin kind = K_BAD;   step = 2'd1; end
        endcase
    end

    assign o_uop.kind   = kind;
    assign o_uop.opa    = i_word.first_operand;
    assign o_uop.opb    = i_word.second_operand;
    assign o_uop.rd_val = i_word.read_value;
    assign o_uop.step   = step;

endmodule

`default_nettype wire

FILE: src/bcpu_queue.sv
// Small FIFO of decoded instructions between decode and execute.
// Depends on bcpu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bcpu_queue
    import bcpu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_uop i_push_uop,
    output logic o_can_push,
    output logic o_valid,
    output t_uop o_uop,
    input  logic i_pop
);

    t_uop                r_slot [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic [QUEUE_CW-1:0] n_count;
    logic                do_push;
    logic                do_pop;

    assign o_can_push = r_count < QUEUE_CW'(QUEUE_DEPTH);
    assign o_valid    = r_count != '0;
    assign o_uop      = r_slot[r_rd_ptr];
    assign do_push    = i_push && o_can_push;
    assign do_pop     = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push_uop;
        end
    end

    `BCPU_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QUEUE_CW'(QUEUE_DEPTH), "queue count overrun")
    `BCPU_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && (r_count == '0), "pop from empty queue")

endmodule

`default_nettype wire

FILE: src/bcpu_exec.sv
// Back end: executes decoded instructions, holds pc, registers, return stack
// and code size, and drives the registered result word. Depends on bcpu_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bcpu_exec
    import bcpu_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    input  logic [8:0] i_cfg_data,
    input  logic       i_uop_valid,
    input  t_uop       i_uop,
    output logic       o_pop,
    output logic       o_out_valid,
    output t_out_word  o_out_word,
    input  logic       i_out_ready
);

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    logic [7:0]     r_pc;
    logic [7:0]     r_regs [4];
    logic [SPW-1:0] r_sp;
    logic [7:0]     r_stack [STACK_DEPTH];
    logic [7:0]     r_top;          // copy of the stack entry below r_sp
    logic [8:0]     r_code_size;
    logic           r_out_valid;
    t_out_word      r_out;

    logic [7:0]     n_pc;
    logic [SPW-1:0] n_sp;
    t_out_word      n_res;
    logic           fire;
    logic           halt_in;
    logic [1:0]     ra;
    logic [1:0]     rb;
    logic [7:0]     rav;
    logic [7:0]     rbv;
    logic [7:0]     pc_step;
    logic           stk_full;
    logic           stk_empty;
    logic           want_push;
    logic           want_pop;
    logic           push_en;
    logic           pop_en;
    logic           wr_en;
    logic [SPW-1:0] sp_dec;
    logic [AW-1:0]  rd_addr;

    assign fire      = i_uop_valid && (!r_out_valid || i_out_ready);
    assign o_pop     = fire;
    assign halt_in   = {1'b0, r_pc} >= r_code_size;
    assign ra        = i_uop.opa[1:0];
    assign rb        = i_uop.opb[1:0];
    assign rav       = r_regs[ra];
    assign rbv       = r_regs[rb];
    assign pc_step   = r_pc + {6'b0, i_uop.step};
    assign stk_full  = r_sp == SPW'(STACK_DEPTH);
    assign stk_empty = r_sp == '0;

    always_comb begin
        n_res     = '0;
        n_pc      = r_pc;
        want_push = 1'b0;
        want_pop  = 1'b0;
        if (halt_in) begin
            // already halted: item is dropped, state holds
            n_res.next_pc = r_pc;
            n_res.halted  = 1'b1;
        end else begin
            n_pc = pc_step;
            unique case (i_uop.kind)
                K_NOP: ;
                K_LOAD: begin
                    n_res.reg_write_en    = 1'b1;
                    n_res.reg_write_index = ra;
                    n_res.reg_write_value = i_uop.opb;
                end
                K_ADD: begin
                    n_res.reg_write_en    = 1'b1;
                    n_res.reg_write_index = ra;
                    n_res.reg_write_value = rav + rbv;
                end
                K_SUB: begin
                    n_res.reg_write_en    = 1'b1;
                    n_res.reg_write_index = ra;
                    n_res.reg_write_value = rav - rbv;
                end
                K_STORE: begin
                    n_res.store_en   = 1'b1;
                    n_res.store_addr = i_uop.opb;
                    n_res.store_data = rav;
                end
                K_READ: begin
                    n_res.reg_write_en    = 1'b1;
                    n_res.reg_write_index = ra;
                    n_res.reg_write_value = i_uop.rd_val;
                end
                K_WRITE: begin
                    n_res.out_en    = 1'b1;
                    n_res.out_value = rav;
                end
                K_JMP: begin
                    n_pc = i_uop.opa;
                end
                K_CALL: begin
                    if (stk_full) begin
                        n_res.error_code = ERR_OVERFLOW;
                    end else begin
                        want_push = 1'b1;
                        n_pc      = i_uop.opa;
                    end
                end
                K_RET: begin
                    if (stk_empty) begin
                        n_res.error_code = ERR_UNDERFLOW;
                    end else begin
                        want_pop = 1'b1;
                        n_pc     = r_top;
                    end
                end
                K_BEQ: begin
                    if (rav == 8'd0) begin
                        n_pc = i_uop.opb;
                    end
                end
                K_BNE: begin
                    if (rav != 8'd0) begin
                        n_pc = i_uop.opb;
                    end
                end
                K_INT: begin
                    n_res.interrupt = 1'b1;
                end
                default: begin
                    n_res.error_code = ERR_BAD_OP;
                end
            endcase
            n_res.next_pc = n_pc;
            n_res.halted  = {1'b0, n_pc} >= r_code_size;
        end
    end

    assign push_en = fire && want_push;
    assign pop_en  = fire && want_pop;
    assign wr_en   = fire && n_res.reg_write_en;

    always_comb begin
        n_sp = r_sp;
        if (push_en) begin
            n_sp = r_sp + 1'b1;
        end else if (pop_en) begin
            n_sp = r_sp - 1'b1;
        end
    end

    // prefetch the new top entry so a RET can use it in the next cycle
    assign sp_dec  = n_sp - 1'b1;
    assign rd_addr = (n_sp == '0) ? '0 : sp_dec[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_sp        <= '0;
            r_code_size <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_code_size <= i_cfg_data;
            end
            if (fire) begin
                r_pc <= n_pc;
            end
            r_sp <= n_sp;
            if (wr_en) begin
                r_regs[ra] <= n_res.reg_write_value;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_sp[AW-1:0]] <= pc_step;
        end
        if (push_en) begin
            r_top <= pc_step;
        end else begin
            r_top <= r_stack[rd_addr];
        end
        if (fire) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    `BCPU_ASSERT(a_sp_bound, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH), "stack pointer past depth")
    `BCPU_ASSERT(a_ret_pop, i_clk, i_rst_n, pop_en |=> (r_sp == $past(r_sp) - 1'b1), "RET did not pop")

endmodule

`default_nettype wire

FILE: src/byte_cpu_instruction_step.sv
// Byte CPU instruction step. A 2-entry queue holds decoded words and decouples
// input; execute takes the oldest into the output register while the output is
// not stalled. Throughput: one instruction per cycle while the output is ready,
// set by the execute loop over pc, registers and return stack top.
// Reset clears pc, registers, stack pointer, code size and queue; the return
// stack memory is not cleared and no clearing pass runs.
`default_nettype none

module byte_cpu_instruction_step
    import bcpu_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [8:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word
);

    t_uop dec_uop;
    t_uop q_uop;
    logic q_valid;
    logic q_pop;

    assign o_cfg_ready = 1'b1;

    bcpu_decode u_decode (
        .i_word (i_in_word),
        .o_uop  (dec_uop)
    );

    bcpu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_in_valid),
        .i_push_uop (dec_uop),
        .o_can_push (o_in_ready),
        .o_valid    (q_valid),
        .o_uop      (q_uop),
        .i_pop      (q_pop)
    );

    bcpu_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_uop_valid (q_valid),
        .i_uop       (q_uop),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

endmodule

`default_nettype wire
